// ----- sv/hacs_pkg.sv -----
// Shared types, constants and calendar helpers for the hold-accelerated clock setter.
package hacs_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned REPEAT_W = 10;
  localparam int unsigned THRESH_W = 12;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Calendar limits.
  localparam logic [YEAR_W-1:0]   YEAR_BASE   = 12'd2000;
  localparam logic [YEAR_W-1:0]   YEAR_LAST   = 12'd2099;
  localparam logic [OFFSET_W-1:0] OFFSET_LAST = 7'd99;
  localparam logic [MONTH_W-1:0]  MONTH_LAST  = 4'd12;
  localparam logic [HOUR_W-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST = 6'd59;
  localparam logic [SECOND_W-1:0] SECOND_LAST = 6'd59;

  // Register reset values.
  localparam logic [REPEAT_W-1:0] REPEAT_RST    = 10'd200;
  localparam logic [THRESH_W-1:0] MID_THR_RST   = 12'd500;
  localparam logic [THRESH_W-1:0] FAST_THR_RST  = 12'd2000;
  localparam logic [STEP_W-1:0]   SLOW_STEP_RST = 6'd1;
  localparam logic [STEP_W-1:0]   MID_STEP_RST  = 6'd10;
  localparam logic [STEP_W-1:0]   FAST_STEP_RST = 6'd60;

  // Saturation limits of the hold counters.
  localparam logic [THRESH_W-1:0] ELAPSED_MAX = '1;
  localparam logic [REPEAT_W-1:0] SINCE_MAX   = '1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT    = 3'd0,
    CFG_MID_THR   = 3'd1,
    CFG_FAST_THR  = 3'd2,
    CFG_SLOW_STEP = 3'd3,
    CFG_MID_STEP  = 3'd4,
    CFG_FAST_STEP = 3'd5
  } cfg_idx_t;

  // Days in a month; within 2000..2099 every fourth year is a leap year.
  function automatic logic [DAY_W-1:0] days_in_month(input logic [OFFSET_W-1:0] offset,
                                                     input logic [MONTH_W-1:0] month);
    logic leap;
    leap = (offset[1:0] == 2'b00);
    case (month)
      4'd2:    days_in_month = leap ? 5'd29 : 5'd28;
      4'd4:    days_in_month = 5'd30;
      4'd6:    days_in_month = 5'd30;
      4'd9:    days_in_month = 5'd30;
      4'd11:   days_in_month = 5'd30;
      default: days_in_month = 5'd31;
    endcase
  endfunction

endpackage

// ----- sv/hold_accelerated_clock_setter.sv -----
// Top level of the hold-accelerated clock setter: input register, calendar step, result register.
module hold_accelerated_clock_setter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic                            up_button,
  input  logic                            down_button,
  input  logic [hacs_pkg::YEAR_W-1:0]     load_year,
  input  logic [hacs_pkg::MONTH_W-1:0]    load_month,
  input  logic [hacs_pkg::DAY_W-1:0]      load_day,
  input  logic [hacs_pkg::HOUR_W-1:0]     load_hour,
  input  logic [hacs_pkg::MINUTE_W-1:0]   load_minute,
  input  logic [hacs_pkg::SECOND_W-1:0]   load_second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hacs_pkg::YEAR_W-1:0]     year,
  output logic [hacs_pkg::MONTH_W-1:0]    month,
  output logic [hacs_pkg::DAY_W-1:0]      day,
  output logic [hacs_pkg::HOUR_W-1:0]     hour,
  output logic [hacs_pkg::MINUTE_W-1:0]   minute,
  output logic [hacs_pkg::SECOND_W-1:0]   second,
  output logic                            adjusted,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hacs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hacs_pkg::CFG_DATA_W-1:0] cfg_data
);
  // Every item (a load or a one-millisecond tick) yields exactly one result. The block takes
  // one item per cycle while the result side does not stall; an accepted item sits in the
  // input register while the calendar update works on it, and the update writes the clock
  // state and the result register together as the item leaves. Back-pressure on the result
  // side stalls the input register, so a stalled result holds and at most two items are in
  // flight. A step of up to 63 minutes, with its hour, day, month and year carry or borrow,
  // is resolved combinationally in that single update. Configuration writes are taken at
  // once and should be made while idle.
  import hacs_pkg::*;

  // Input register.
  logic                  s1_valid;
  logic                  s1_command;
  logic                  s1_up;
  logic                  s1_down;
  logic [YEAR_W-1:0]     s1_year;
  logic [MONTH_W-1:0]    s1_month;
  logic [DAY_W-1:0]      s1_day;
  logic [HOUR_W-1:0]     s1_hour;
  logic [MINUTE_W-1:0]   s1_minute;
  logic [SECOND_W-1:0]   s1_second;
  logic                  advance;

  // Configuration registers.
  logic [REPEAT_W-1:0]   repeat_interval;
  logic [THRESH_W-1:0]   mid_threshold;
  logic [THRESH_W-1:0]   fast_threshold;
  logic [STEP_W-1:0]     slow_step;
  logic [STEP_W-1:0]     mid_step;
  logic [STEP_W-1:0]     fast_step;

  // Clock and hold state.
  logic [OFFSET_W-1:0]   year_offset;
  logic [MONTH_W-1:0]    month_reg;
  logic [DAY_W-1:0]      day_reg;
  logic [HOUR_W-1:0]     hour_reg;
  logic [MINUTE_W-1:0]   minute_reg;
  logic [SECOND_W-1:0]   second_reg;
  dir_t                  held_direction;
  logic [THRESH_W-1:0]   press_elapsed;
  logic [REPEAT_W-1:0]   since_step;

  logic [OFFSET_W-1:0]   year_offset_next;
  logic [MONTH_W-1:0]    month_reg_next;
  logic [DAY_W-1:0]      day_reg_next;
  logic [HOUR_W-1:0]     hour_reg_next;
  logic [MINUTE_W-1:0]   minute_reg_next;
  logic [SECOND_W-1:0]   second_reg_next;
  dir_t                  held_direction_next;
  logic [THRESH_W-1:0]   press_elapsed_next;
  logic [REPEAT_W-1:0]   since_step_next;
  logic                  adjusted_next;

  // Load path.
  logic [OFFSET_W-1:0]   ld_offset;
  logic [MONTH_W-1:0]    ld_month;
  logic [DAY_W-1:0]      ld_dim;
  logic [DAY_W-1:0]      ld_day;

  // Tick path.
  dir_t                  dir;
  logic [THRESH_W-1:0]   elapsed_inc;
  logic [REPEAT_W-1:0]   since_inc;
  logic                  press_start;
  logic                  repeat_hit;
  logic                  do_step;
  logic [STEP_W-1:0]     amount;

  // Step up.
  logic [MINUTE_W:0]     up_sum;
  logic [1:0]            up_carry;
  logic [MINUTE_W-1:0]   up_minute;
  logic [HOUR_W-1:0]     up_hsum;
  logic                  up_day_carry;
  logic [HOUR_W-1:0]     up_hour;
  logic [DAY_W-1:0]      cur_dim;
  logic [OFFSET_W-1:0]   up_offset;
  logic [MONTH_W-1:0]    up_month;
  logic [DAY_W-1:0]      up_day;

  // Step down.
  logic [MINUTE_W+1:0]   dn_sum;
  logic [1:0]            dn_borrow;
  logic [MINUTE_W-1:0]   dn_minute;
  logic [HOUR_W:0]       dn_hsum;
  logic                  dn_day_borrow;
  logic [HOUR_W-1:0]     dn_hour;
  logic [OFFSET_W-1:0]   dn_offset;
  logic [MONTH_W-1:0]    dn_month;
  logic [DAY_W-1:0]      dn_day;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  // Input register: holds an item until the result register can take its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_command <= command;
      s1_up      <= up_button;
      s1_down    <= down_button;
      s1_year    <= load_year;
      s1_month   <= load_month;
      s1_day     <= load_day;
      s1_hour    <= load_hour;
      s1_minute  <= load_minute;
      s1_second  <= load_second;
    end
  end

  // Configuration register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_interval <= REPEAT_RST;
      mid_threshold   <= MID_THR_RST;
      fast_threshold  <= FAST_THR_RST;
      slow_step       <= SLOW_STEP_RST;
      mid_step        <= MID_STEP_RST;
      fast_step       <= FAST_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REPEAT:    repeat_interval <= cfg_data[REPEAT_W-1:0];
        CFG_MID_THR:   mid_threshold   <= cfg_data[THRESH_W-1:0];
        CFG_FAST_THR:  fast_threshold  <= cfg_data[THRESH_W-1:0];
        CFG_SLOW_STEP: slow_step       <= cfg_data[STEP_W-1:0];
        CFG_MID_STEP:  mid_step        <= cfg_data[STEP_W-1:0];
        CFG_FAST_STEP: fast_step       <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Load values saturated into range; the day is limited by its own month.
  always_comb begin
    if (s1_year < YEAR_BASE) begin
      ld_offset = '0;
    end else if (s1_year > YEAR_LAST) begin
      ld_offset = OFFSET_LAST;
    end else begin
      ld_offset = OFFSET_W'(s1_year - YEAR_BASE);
    end
    if (s1_month == '0) begin
      ld_month = 4'd1;
    end else if (s1_month > MONTH_LAST) begin
      ld_month = MONTH_LAST;
    end else begin
      ld_month = s1_month;
    end
    ld_dim = days_in_month(ld_offset, ld_month);
    if (s1_day == '0) begin
      ld_day = 5'd1;
    end else if (s1_day > ld_dim) begin
      ld_day = ld_dim;
    end else begin
      ld_day = s1_day;
    end
  end

  // Button direction, hold counters and step size.
  always_comb begin
    if (held_direction == DIR_UP && s1_up) begin
      dir = DIR_UP;
    end else if (held_direction == DIR_DOWN && s1_down) begin
      dir = DIR_DOWN;
    end else if (s1_up) begin
      dir = DIR_UP;
    end else if (s1_down) begin
      dir = DIR_DOWN;
    end else begin
      dir = DIR_NONE;
    end
    elapsed_inc = (press_elapsed == ELAPSED_MAX) ? press_elapsed : press_elapsed + 1'b1;
    since_inc   = (since_step == SINCE_MAX) ? since_step : since_step + 1'b1;
    press_start = (dir != DIR_NONE) && (dir != held_direction);
    repeat_hit  = (since_inc >= repeat_interval);
    do_step     = press_start || ((dir != DIR_NONE) && repeat_hit);
    if (press_start) begin
      amount = slow_step;
    end else if (elapsed_inc > fast_threshold) begin
      amount = fast_step;
    end else if (elapsed_inc > mid_threshold) begin
      amount = mid_step;
    end else begin
      amount = slow_step;
    end
  end

  // Forward step: at most two hour carries and one day carry.
  always_comb begin
    cur_dim = days_in_month(year_offset, month_reg);
    up_sum  = {1'b0, minute_reg} + {1'b0, amount};
    if (up_sum >= 7'd120) begin
      up_carry  = 2'd2;
      up_minute = MINUTE_W'(up_sum - 7'd120);
    end else if (up_sum >= 7'd60) begin
      up_carry  = 2'd1;
      up_minute = MINUTE_W'(up_sum - 7'd60);
    end else begin
      up_carry  = 2'd0;
      up_minute = up_sum[MINUTE_W-1:0];
    end
    up_hsum      = hour_reg + {3'b0, up_carry};
    up_day_carry = (up_hsum >= 5'd24);
    up_hour      = up_day_carry ? up_hsum - 5'd24 : up_hsum;
    up_offset    = year_offset;
    up_month     = month_reg;
    up_day       = day_reg;
    if (up_day_carry) begin
      if (day_reg >= cur_dim) begin
        up_day = 5'd1;
        if (month_reg >= MONTH_LAST) begin
          up_month  = 4'd1;
          up_offset = (year_offset >= OFFSET_LAST) ? '0 : year_offset + 1'b1;
        end else begin
          up_month = month_reg + 1'b1;
        end
      end else begin
        up_day = day_reg + 1'b1;
      end
    end
  end

  // Backward step: the minute is biased by two hours so the borrow stays unsigned.
  always_comb begin
    dn_sum = {2'b0, minute_reg} + 8'd120 - {2'b0, amount};
    if (dn_sum >= 8'd120) begin
      dn_borrow = 2'd0;
      dn_minute = MINUTE_W'(dn_sum - 8'd120);
    end else if (dn_sum >= 8'd60) begin
      dn_borrow = 2'd1;
      dn_minute = MINUTE_W'(dn_sum - 8'd60);
    end else begin
      dn_borrow = 2'd2;
      dn_minute = dn_sum[MINUTE_W-1:0];
    end
    dn_hsum       = {1'b0, hour_reg} + 6'd24 - {4'b0, dn_borrow};
    dn_day_borrow = (dn_hsum < 6'd24);
    dn_hour       = dn_day_borrow ? dn_hsum[HOUR_W-1:0] : HOUR_W'(dn_hsum - 6'd24);
    dn_offset     = year_offset;
    dn_month      = month_reg;
    dn_day        = day_reg;
    if (dn_day_borrow) begin
      if (day_reg <= 5'd1) begin
        if (month_reg <= 4'd1) begin
          dn_month  = MONTH_LAST;
          dn_offset = (year_offset == '0) ? OFFSET_LAST : year_offset - 1'b1;
        end else begin
          dn_month = month_reg - 1'b1;
        end
        dn_day = days_in_month(dn_offset, dn_month);
      end else begin
        dn_day = day_reg - 1'b1;
      end
    end
  end

  // Next clock and hold state.
  always_comb begin
    year_offset_next    = year_offset;
    month_reg_next      = month_reg;
    day_reg_next        = day_reg;
    hour_reg_next       = hour_reg;
    minute_reg_next     = minute_reg;
    second_reg_next     = second_reg;
    held_direction_next = held_direction;
    press_elapsed_next  = press_elapsed;
    since_step_next     = since_step;
    adjusted_next       = 1'b0;
    if (s1_command) begin
      year_offset_next    = ld_offset;
      month_reg_next      = ld_month;
      day_reg_next        = ld_day;
      hour_reg_next       = (s1_hour > HOUR_LAST) ? HOUR_LAST : s1_hour;
      minute_reg_next     = (s1_minute > MINUTE_LAST) ? MINUTE_LAST : s1_minute;
      second_reg_next     = (s1_second > SECOND_LAST) ? SECOND_LAST : s1_second;
      held_direction_next = DIR_NONE;
      press_elapsed_next  = '0;
      since_step_next     = '0;
    end else begin
      held_direction_next = dir;
      if (dir == DIR_NONE || press_start) begin
        press_elapsed_next = '0;
        since_step_next    = '0;
      end else begin
        press_elapsed_next = elapsed_inc;
        since_step_next    = repeat_hit ? '0 : since_inc;
      end
      adjusted_next = do_step;
      if (do_step && dir == DIR_UP) begin
        year_offset_next = up_offset;
        month_reg_next   = up_month;
        day_reg_next     = up_day;
        hour_reg_next    = up_hour;
        minute_reg_next  = up_minute;
      end else if (do_step) begin
        year_offset_next = dn_offset;
        month_reg_next   = dn_month;
        day_reg_next     = dn_day;
        hour_reg_next    = dn_hour;
        minute_reg_next  = dn_minute;
      end
    end
  end

  // Clock state, updated as each item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      year_offset    <= '0;
      month_reg      <= 4'd1;
      day_reg        <= 5'd1;
      hour_reg       <= '0;
      minute_reg     <= '0;
      second_reg     <= '0;
      held_direction <= DIR_NONE;
      press_elapsed  <= '0;
      since_step     <= '0;
    end else if (advance) begin
      year_offset    <= year_offset_next;
      month_reg      <= month_reg_next;
      day_reg        <= day_reg_next;
      hour_reg       <= hour_reg_next;
      minute_reg     <= minute_reg_next;
      second_reg     <= second_reg_next;
      held_direction <= held_direction_next;
      press_elapsed  <= press_elapsed_next;
      since_step     <= since_step_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      year     <= YEAR_BASE + {5'b0, year_offset_next};
      month    <= month_reg_next;
      day      <= day_reg_next;
      hour     <= hour_reg_next;
      minute   <= minute_reg_next;
      second   <= second_reg_next;
      adjusted <= adjusted_next;
    end
  end

endmodule

// ----- sv/hacs_checker.sv -----
// Port-level checks for the hold-accelerated clock setter, bound to the top level.
module hacs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hacs_pkg::YEAR_W-1:0]     year,
  input logic [hacs_pkg::MONTH_W-1:0]    month,
  input logic [hacs_pkg::DAY_W-1:0]      day,
  input logic [hacs_pkg::HOUR_W-1:0]     hour,
  input logic [hacs_pkg::MINUTE_W-1:0]   minute,
  input logic [hacs_pkg::SECOND_W-1:0]   second,
  input logic                            adjusted
);
  import hacs_pkg::*;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // With the result side empty the block always takes an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // Every result lies within the calendar ranges; the day is checked against 31 only.
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (year >= YEAR_BASE && year <= YEAR_LAST && month >= 4'd1 &&
                   month <= MONTH_LAST && day >= 5'd1 && day <= 5'd31 &&
                   hour <= HOUR_LAST && minute <= MINUTE_LAST && second <= SECOND_LAST))
    else $error("result outside the calendar range");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(year) && $stable(month) &&
                                $stable(day) && $stable(hour) && $stable(minute) &&
                                $stable(second) && $stable(adjusted))
    else $error("stalled result changed");

endmodule

bind hold_accelerated_clock_setter hacs_checker u_hacs_checker (.*);
